// ===== src/sli_pkg.sv =====
`default_nettype none
package sli_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int VALUE_W = 32;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

  typedef struct packed {
    logic ins_here;
    logic del_here;
    logic eq;
  } cell_flags_t;

endpackage
`default_nettype wire

// ===== src/sli_cell.sv =====
`default_nettype none
module sli_cell (
  input  wire                           clk,
  input  wire                           rst,
  input  sli_pkg::cell_cmd_t            cmd,
  input  wire signed [sli_pkg::VALUE_W-1:0] value,
  input  wire signed [sli_pkg::VALUE_W-1:0] left_entry,
  input  wire                           left_valid,
  input  wire                           left_ins,
  input  wire signed [sli_pkg::VALUE_W-1:0] right_entry,
  input  wire                           right_valid,
  output logic signed [sli_pkg::VALUE_W-1:0] entry,
  output logic                          valid,
  output sli_pkg::cell_flags_t          flags
);
  import sli_pkg::*;

  logic signed [VALUE_W-1:0] entry_next;
  logic                      valid_next;

  always_comb begin
    flags.ins_here = !valid || (entry > value);
    flags.del_here = valid && (entry >= value);
    flags.eq       = valid && (entry == value);
  end

  always_comb begin
    entry_next = entry;
    valid_next = valid;
    if (cmd.ins) begin
      if (left_ins) begin
        entry_next = left_entry;
      end else if (flags.ins_here) begin
        entry_next = value;
      end
      valid_next = valid | left_valid;
    end else if (cmd.del) begin
      if (flags.del_here) begin
        entry_next = right_entry;
        valid_next = right_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
      valid <= 1'b0;
    end else begin
      entry <= entry_next;
      valid <= valid_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/sorted_list_insert_delete.sv =====
// Sorted list of signed 32-bit values with insert and delete.
// Input stream: s_tuser[0] is the opcode (insert or delete), s_tdata the value.
// Output stream: one result transaction per input transaction, carrying the
// status (done, not found, full) and the entry count after the operation.
// Each list slot is a cell that compares its entry with the value and takes the value or
// its left or right neighbour's entry, so a whole operation finishes in the
// cycle it is accepted. The result goes straight into the output register;
// throughput is one transaction per cycle while the receiver keeps up.
// When m_tready is low the result is held and s_tready drops until the
// result is taken, so nothing is lost or duplicated.
// Reset (rst, synchronous, active high) empties the list, clears every
// cell to zero and drops m_tvalid; the block accepts input the cycle after.
// Full is detected from the last cell's occupancy; a delete match is the
// OR of every cell's equality flag.
`default_nettype none
module sorted_list_insert_delete #(
  parameter int CAPACITY = sli_pkg::DEF_CAPACITY
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [31:0] s_tdata,   // [31:0] value
  input  wire [0:0]  s_tuser,   // [0] opcode
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata    // [1:0] status, [6:2] entry_count, [7] zero
);
  import sli_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [VALUE_W-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]       valids;
  logic [CAPACITY-1:0]       ins_flags;
  logic [CAPACITY-1:0]       eq_flags;
  cell_flags_t               flags [CAPACITY];
  cell_cmd_t                 cmd;

  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic [CW+COUNT_OUT_W-1:0] count_ext;
  logic                      accept;
  logic                      full;
  logic                      found;
  opcode_t                   opcode;
  logic signed [VALUE_W-1:0] value;
  status_t                   status_next;
  status_t                   status;
  logic [COUNT_OUT_W-1:0]    count_out;

  assign opcode   = opcode_t'(s_tuser[0]);
  assign value    = s_tdata;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = valids[CAPACITY-1];
  assign found    = |eq_flags;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] l_entry;
      logic                      l_valid;
      logic                      l_ins;
      logic signed [VALUE_W-1:0] r_entry;
      logic                      r_valid;

      if (i == 0) begin : g_first
        assign l_entry = '0;
        assign l_valid = 1'b1;
        assign l_ins   = 1'b0;
      end else begin : g_mid
        assign l_entry = entries[i-1];
        assign l_valid = valids[i-1];
        assign l_ins   = ins_flags[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign r_entry = '0;
        assign r_valid = 1'b0;
      end else begin : g_body
        assign r_entry = entries[i+1];
        assign r_valid = valids[i+1];
      end

      sli_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmd         (cmd),
        .value       (value),
        .left_entry  (l_entry),
        .left_valid  (l_valid),
        .left_ins    (l_ins),
        .right_entry (r_entry),
        .right_valid (r_valid),
        .entry       (entries[i]),
        .valid       (valids[i]),
        .flags       (flags[i])
      );

      assign ins_flags[i] = flags[i].ins_here;
      assign eq_flags[i]  = flags[i].eq;
    end
  endgenerate

  always_comb begin
    cmd         = '0;
    count_next  = count;
    status_next = ST_DONE;
    unique case (opcode)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd.ins    = accept;
          count_next = count + CW'(1);
        end
      end
      OP_DELETE: begin
        if (!found) begin
          status_next = ST_NOT_FOUND;
        end else begin
          cmd.del    = accept;
          count_next = count - CW'(1);
        end
      end
      default: status_next = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

  assign count_ext = {{COUNT_OUT_W{1'b0}}, count};
  assign count_out = count_ext[COUNT_OUT_W-1:0];
  assign m_tdata   = {1'b0, count_out, status};

  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valids) == count)
    else $error("count disagrees with occupied cells");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the list");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.del |=> count == $past(count) - CW'(1))
    else $error("delete did not shrink the list");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == ST_FULL) |-> (count == CW'(CAPACITY)))
    else $error("full status with free slots");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted transaction gave no result");

endmodule
`default_nettype wire
